>>> src/ocpu_pkg.sv
// ----------------------------------------------------------------------------
// ocpu_pkg
// Shared widths, register codes, sideband types and CORDIC angle table.
// ----------------------------------------------------------------------------
package ocpu_pkg;

   localparam int XW = 36;
   localparam int ZW = 34;

   localparam logic CSR_MODEL_MODE      = 1'b0;
   localparam logic CSR_MIN_TRANSLATION = 1'b1;

   localparam logic [1:0] MODE_OMNI = 2'd0;
   localparam logic [1:0] MODE_DIFF = 2'd1;

   localparam logic [31:0] ATAN_TAB [24] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81
   };

   typedef struct packed {
      logic [15:0] prev_h;
      logic [15:0] ph;
      logic [15:0] out_h;
      logic [31:0] px;
      logic [31:0] py;
      logic        nz;
      logic        ok;
   } vside_type;

   typedef struct packed {
      logic [15:0] out_h;
      logic [31:0] px;
      logic [31:0] py;
      logic        ok;
   } rside_type;

   // x gain of a rotation run on (2^30, 0) at zero angle
   function automatic longint cordic_kx(input int stages);
      longint x;
      longint y;
      longint z;
      longint xs;
      longint ys;
      x = longint'(1) <<< 30;
      y = 0;
      z = 0;
      for (int i = 0; i < 24; i++) begin
         if (i < stages) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
               x = x - ys;
               y = y + xs;
               z = z - longint'(ATAN_TAB[i]);
            end else begin
               x = x + ys;
               y = y - xs;
               z = z + longint'(ATAN_TAB[i]);
            end
         end
      end
      return x;
   endfunction

endpackage

>>> src/odometry_pose_update_core.sv
// ----------------------------------------------------------------------------
// odometry_pose_update_core
// Odometry motion update of one pose per transaction, omni or differential.
//
// The req_ channel carries two odometry readings and a pose; the rsp_
// channel returns the updated pose and model_ok. A transaction moves on a
// channel at a clock edge with valid high and stall low. The csr_ channel
// writes model_mode (index 0) and min_translation (index 1); csr_ready is
// always high, and writes belong in idle time.
// From request to response a transaction passes the input register, the
// vectoring cell row, two gain-multiply stages, the travel angle stage,
// the rotation cell row, three scale and saturate stages and the output
// register. One transaction is taken every cycle while req_stall is low.
// When rsp_stall is held the pipeline keeps running until one result sits
// in the skid register behind the output register; req_stall then rises
// and the whole pipeline holds. Reset clears all valid bits and sets
// model_mode to differential and min_translation to 655.
// ----------------------------------------------------------------------------
module odometry_pose_update_core import ocpu_pkg::*; #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_prev_odom_x,
   input  logic [31:0] req_prev_odom_y,
   input  logic [15:0] req_prev_odom_heading,
   input  logic [31:0] req_new_odom_x,
   input  logic [31:0] req_new_odom_y,
   input  logic [15:0] req_new_odom_heading,
   input  logic [31:0] req_pose_x,
   input  logic [31:0] req_pose_y,
   input  logic [15:0] req_pose_heading,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_x,
   output logic [31:0] rsp_out_y,
   output logic [15:0] rsp_out_heading,
   output logic        rsp_model_ok,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam longint KX = cordic_kx(CORDIC_STAGES);
   localparam longint IK_FULL = ((longint'(1) <<< 60) + (KX >>> 1)) / KX;
   localparam logic [29:0] IK = IK_FULL[29:0];
   localparam int VSW = $bits(vside_type);
   localparam int RSW = $bits(rside_type);

   logic [1:0]  mode_ff;
   logic [15:0] min_trans_ff;
   logic        en;
   logic        mode_ok;

   // configuration
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_DIFF;
         min_trans_ff <= 16'd655;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MODEL_MODE:      mode_ff      <= csr_wdata[1:0];
            CSR_MIN_TRANSLATION: min_trans_ff <= csr_wdata;
            default:             mode_ff      <= mode_ff;
         endcase
      end
   end
   assign mode_ok = (mode_ff == MODE_OMNI) || (mode_ff == MODE_DIFF);

   // input stage
   logic            s0_valid_ff;
   logic [32:0]     dx_ff, dy_ff;
   vside_type       s0_side_ff;
   logic [XW-1:0]   v0_x, v0_y;
   logic [ZW-1:0]   v0_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff <= {req_new_odom_x[31], req_new_odom_x}
                  - {req_prev_odom_x[31], req_prev_odom_x};
         dy_ff <= {req_new_odom_y[31], req_new_odom_y}
                  - {req_prev_odom_y[31], req_prev_odom_y};
         s0_side_ff.prev_h <= req_prev_odom_heading;
         s0_side_ff.ph     <= req_pose_heading;
         s0_side_ff.out_h  <= mode_ok
                              ? req_pose_heading + req_new_odom_heading
                                - req_prev_odom_heading
                              : req_pose_heading;
         s0_side_ff.px     <= req_pose_x;
         s0_side_ff.py     <= req_pose_y;
         s0_side_ff.nz     <= (req_new_odom_x != req_prev_odom_x)
                              || (req_new_odom_y != req_prev_odom_y);
         s0_side_ff.ok     <= mode_ok;
      end
   end

   always_comb begin
      if (dx_ff[32]) begin
         v0_x = XW'(-$signed(dx_ff));
         v0_y = XW'(-$signed(dy_ff));
         v0_z = {{(ZW-32){1'b0}}, 32'h8000_0000};
      end else begin
         v0_x = XW'($signed(dx_ff));
         v0_y = XW'($signed(dy_ff));
         v0_z = '0;
      end
   end

   logic            vc_valid;
   logic [XW-1:0]   vc_x, vc_y;
   logic [ZW-1:0]   vc_z;
   logic [VSW-1:0]  vc_side_bits;
   vside_type       vc_side;

   ocpu_cordic_chain #(
      .STAGES(CORDIC_STAGES), .VECTORING(1'b1), .SIDE_W(VSW)
   ) u_vec (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(s0_valid_ff), .in_x(v0_x), .in_y(v0_y), .in_z(v0_z),
      .in_side(s0_side_ff),
      .out_valid(vc_valid), .out_x(vc_x), .out_y(vc_y), .out_z(vc_z),
      .out_side(vc_side_bits)
   );
   assign vc_side = vc_side_bits;

   // gain removal on distance, bearing rounding
   logic            m1_valid_ff, m2_valid_ff, m3_valid_ff;
   logic [47:0]     m1_lo_ff, m1_hi_ff;
   logic [15:0]     m1_bear_ff, m2_bear_ff;
   vside_type       m1_side_ff, m2_side_ff;
   logic [XW-1:0]   m2_trans_ff, m3_trans_ff;
   logic [67:0]     m2_sum;
   logic [15:0]     m3_travel_ff;
   rside_type       m3_side_ff;
   logic [15:0]     rot1;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         m3_valid_ff <= 1'b0;
      end else if (en) begin
         m1_valid_ff <= vc_valid;
         m2_valid_ff <= m1_valid_ff;
         m3_valid_ff <= m2_valid_ff;
      end
   end

   assign m2_sum = ({20'd0, m1_hi_ff} << 18) + {20'd0, m1_lo_ff}
                   + (68'd1 << 29);

   always_comb begin
      if ((mode_ff == MODE_DIFF) && (m2_trans_ff < {{(XW-16){1'b0}}, min_trans_ff})) begin
         rot1 = '0;
      end else begin
         rot1 = m2_bear_ff - m2_side_ff.prev_h;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_lo_ff   <= {30'd0, vc_x[17:0]} * {18'd0, IK};
         m1_hi_ff   <= {30'd0, vc_x[35:18]} * {18'd0, IK};
         m1_bear_ff <= vc_side.nz ? vc_z[31:16] + {15'd0, vc_z[15]} : 16'd0;
         m1_side_ff <= vc_side;
         m2_trans_ff <= m1_side_ff.nz ? m2_sum[30 +: XW] : '0;
         m2_bear_ff  <= m1_bear_ff;
         m2_side_ff  <= m1_side_ff;
         m3_trans_ff  <= m2_trans_ff;
         m3_travel_ff <= m2_side_ff.ph + rot1;
         m3_side_ff.out_h <= m2_side_ff.out_h;
         m3_side_ff.px    <= m2_side_ff.px;
         m3_side_ff.py    <= m2_side_ff.py;
         m3_side_ff.ok    <= m2_side_ff.ok;
      end
   end

   // rotation by travel angle
   logic [XW-1:0]   r0_x;
   logic [ZW-1:0]   r0_z;
   logic [15:0]     r0_a;

   always_comb begin
      if (m3_travel_ff[15] != m3_travel_ff[14]) begin
         r0_a = {~m3_travel_ff[15], m3_travel_ff[14:0]};
         r0_x = -m3_trans_ff;
      end else begin
         r0_a = m3_travel_ff;
         r0_x = m3_trans_ff;
      end
      r0_z = ZW'($signed({r0_a, 16'd0}));
   end

   logic            rc_valid;
   logic [XW-1:0]   rc_x, rc_y;
   logic [ZW-1:0]   rc_z;
   logic [RSW-1:0]  rc_side_bits;
   rside_type       rc_side;

   ocpu_cordic_chain #(
      .STAGES(CORDIC_STAGES), .VECTORING(1'b0), .SIDE_W(RSW)
   ) u_rot (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(m3_valid_ff), .in_x(r0_x), .in_y('0), .in_z(r0_z),
      .in_side(m3_side_ff),
      .out_valid(rc_valid), .out_x(rc_x), .out_y(rc_y), .out_z(rc_z),
      .out_side(rc_side_bits)
   );
   assign rc_side = rc_side_bits;

   // scale, add and saturate
   logic            r1_valid_ff, r2_valid_ff, r3_valid_ff;
   logic [XW-1:0]   ax, ay;
   logic [47:0]     r1_xlo_ff, r1_xhi_ff, r1_ylo_ff, r1_yhi_ff;
   logic            r1_xneg_ff, r1_yneg_ff;
   rside_type       r1_side_ff, r2_side_ff;
   logic [67:0]     xsum, ysum;
   logic [36:0]     xmag, ymag;
   logic [36:0]     r2_dx_ff, r2_dy_ff;
   logic [37:0]     nx, ny;
   logic [31:0]     r3_x_ff, r3_y_ff, satx, saty;
   logic [15:0]     r3_h_ff;
   logic            r3_ok_ff;

   assign ax = rc_x[XW-1] ? -rc_x : rc_x;
   assign ay = rc_y[XW-1] ? -rc_y : rc_y;
   assign xsum = ({20'd0, r1_xhi_ff} << 18) + {20'd0, r1_xlo_ff} + (68'd1 << 29);
   assign ysum = ({20'd0, r1_yhi_ff} << 18) + {20'd0, r1_ylo_ff} + (68'd1 << 29);
   assign xmag = {1'b0, xsum[65:30]};
   assign ymag = {1'b0, ysum[65:30]};
   assign nx = {{6{r2_side_ff.px[31]}}, r2_side_ff.px} + {r2_dx_ff[36], r2_dx_ff};
   assign ny = {{6{r2_side_ff.py[31]}}, r2_side_ff.py} + {r2_dy_ff[36], r2_dy_ff};

   always_comb begin
      if ($signed(nx) > 38'sd2147483647) begin
         satx = 32'h7FFF_FFFF;
      end else if ($signed(nx) < -38'sd2147483648) begin
         satx = 32'h8000_0000;
      end else begin
         satx = nx[31:0];
      end
      if ($signed(ny) > 38'sd2147483647) begin
         saty = 32'h7FFF_FFFF;
      end else if ($signed(ny) < -38'sd2147483648) begin
         saty = 32'h8000_0000;
      end else begin
         saty = ny[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_valid_ff <= 1'b0;
         r2_valid_ff <= 1'b0;
         r3_valid_ff <= 1'b0;
      end else if (en) begin
         r1_valid_ff <= rc_valid;
         r2_valid_ff <= r1_valid_ff;
         r3_valid_ff <= r2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r1_xlo_ff  <= {30'd0, ax[17:0]} * {18'd0, IK};
         r1_xhi_ff  <= {30'd0, ax[35:18]} * {18'd0, IK};
         r1_ylo_ff  <= {30'd0, ay[17:0]} * {18'd0, IK};
         r1_yhi_ff  <= {30'd0, ay[35:18]} * {18'd0, IK};
         r1_xneg_ff <= rc_x[XW-1];
         r1_yneg_ff <= rc_y[XW-1];
         r1_side_ff <= rc_side;
         r2_dx_ff   <= r1_xneg_ff ? -xmag : xmag;
         r2_dy_ff   <= r1_yneg_ff ? -ymag : ymag;
         r2_side_ff <= r1_side_ff;
         r3_x_ff    <= r2_side_ff.ok ? satx : r2_side_ff.px;
         r3_y_ff    <= r2_side_ff.ok ? saty : r2_side_ff.py;
         r3_h_ff    <= r2_side_ff.out_h;
         r3_ok_ff   <= r2_side_ff.ok;
      end
   end

   // output register and skid
   logic        out_valid_ff, skid_valid_ff;
   logic [31:0] out_x_ff, out_y_ff, skid_x_ff, skid_y_ff;
   logic [15:0] out_h_ff, skid_h_ff;
   logic        out_ok_ff, skid_ok_ff;
   logic        push;

   assign en   = ~skid_valid_ff;
   assign push = en & r3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_valid_ff && rsp_stall) begin
         if (push) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (skid_valid_ff) begin
         out_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= push;
      end
   end

   always_ff @(posedge clock) begin
      if (out_valid_ff && rsp_stall) begin
         if (push) begin
            skid_x_ff  <= r3_x_ff;
            skid_y_ff  <= r3_y_ff;
            skid_h_ff  <= r3_h_ff;
            skid_ok_ff <= r3_ok_ff;
         end
      end else if (skid_valid_ff) begin
         out_x_ff  <= skid_x_ff;
         out_y_ff  <= skid_y_ff;
         out_h_ff  <= skid_h_ff;
         out_ok_ff <= skid_ok_ff;
      end else if (push) begin
         out_x_ff  <= r3_x_ff;
         out_y_ff  <= r3_y_ff;
         out_h_ff  <= r3_h_ff;
         out_ok_ff <= r3_ok_ff;
      end
   end

   assign req_stall       = skid_valid_ff;
   assign rsp_valid       = out_valid_ff;
   assign rsp_out_x       = out_x_ff;
   assign rsp_out_y       = out_y_ff;
   assign rsp_out_heading = out_h_ff;
   assign rsp_model_ok    = out_ok_ff;

endmodule

>>> src/ocpu_cordic_cell.sv
// ----------------------------------------------------------------------------
// ocpu_cordic_cell
// One CORDIC micro-rotation, registered, with sideband carried along.
// ----------------------------------------------------------------------------
module ocpu_cordic_cell import ocpu_pkg::*; #(
   parameter int SHIFT     = 0,
   parameter bit VECTORING = 1'b0,
   parameter int SIDE_W    = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [XW-1:0]     in_x,
   input  logic [XW-1:0]     in_y,
   input  logic [ZW-1:0]     in_z,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [XW-1:0]     out_x,
   output logic [XW-1:0]     out_y,
   output logic [ZW-1:0]     out_z,
   output logic [SIDE_W-1:0] out_side
);

   localparam logic [ZW-1:0] ANG = {{(ZW-32){1'b0}}, ATAN_TAB[SHIFT]};

   logic              valid_ff;
   logic [XW-1:0]     x_ff, x_in, y_ff, y_in;
   logic [ZW-1:0]     z_ff, z_in;
   logic [SIDE_W-1:0] side_ff;
   logic [XW-1:0]     xs, ys;
   logic              dir;

   always_comb begin
      xs  = XW'($signed(in_x) >>> SHIFT);
      ys  = XW'($signed(in_y) >>> SHIFT);
      dir = VECTORING ? ~in_y[XW-1] : in_z[ZW-1];
      if (VECTORING) begin
         if (dir) begin
            x_in = in_x + ys;
            y_in = in_y - xs;
            z_in = in_z + ANG;
         end else begin
            x_in = in_x - ys;
            y_in = in_y + xs;
            z_in = in_z - ANG;
         end
      end else begin
         if (!dir) begin
            x_in = in_x - ys;
            y_in = in_y + xs;
            z_in = in_z - ANG;
         end else begin
            x_in = in_x + ys;
            y_in = in_y - xs;
            z_in = in_z + ANG;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule

>>> src/ocpu_cordic_chain.sv
// ----------------------------------------------------------------------------
// ocpu_cordic_chain
// Row of CORDIC cells, one micro-rotation per stage.
// ----------------------------------------------------------------------------
module ocpu_cordic_chain import ocpu_pkg::*; #(
   parameter int STAGES    = 16,
   parameter bit VECTORING = 1'b0,
   parameter int SIDE_W    = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [XW-1:0]     in_x,
   input  logic [XW-1:0]     in_y,
   input  logic [ZW-1:0]     in_z,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [XW-1:0]     out_x,
   output logic [XW-1:0]     out_y,
   output logic [ZW-1:0]     out_z,
   output logic [SIDE_W-1:0] out_side
);

   logic              v_w    [STAGES+1];
   logic [XW-1:0]     x_w    [STAGES+1];
   logic [XW-1:0]     y_w    [STAGES+1];
   logic [ZW-1:0]     z_w    [STAGES+1];
   logic [SIDE_W-1:0] side_w [STAGES+1];

   assign v_w[0]    = in_valid;
   assign x_w[0]    = in_x;
   assign y_w[0]    = in_y;
   assign z_w[0]    = in_z;
   assign side_w[0] = in_side;

   for (genvar i = 0; i < STAGES; i++) begin : g_cell
      ocpu_cordic_cell #(
         .SHIFT(i), .VECTORING(VECTORING), .SIDE_W(SIDE_W)
      ) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .in_valid(v_w[i]), .in_x(x_w[i]), .in_y(y_w[i]), .in_z(z_w[i]),
         .in_side(side_w[i]),
         .out_valid(v_w[i+1]), .out_x(x_w[i+1]), .out_y(y_w[i+1]),
         .out_z(z_w[i+1]), .out_side(side_w[i+1])
      );
   end

   assign out_valid = v_w[STAGES];
   assign out_x     = x_w[STAGES];
   assign out_y     = y_w[STAGES];
   assign out_z     = z_w[STAGES];
   assign out_side  = side_w[STAGES];

endmodule

>>> src/ocpu_checker.sv
// ----------------------------------------------------------------------------
// ocpu_checker
// Port-level checks on the pose update core, bound to the top level.
// ----------------------------------------------------------------------------
module ocpu_checker (
   input logic clock,
   input logic reset,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with empty output");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("request stall without a stalled response");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("configuration port not ready");

endmodule

bind odometry_pose_update_core ocpu_checker u_ocpu_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .csr_ready(csr_ready)
);

>>> tb/odometry_pose_update_core_test.sv
// ----------------------------------------------------------------------------
// odometry_pose_update_core_test
// Self-checking bench for the odometry pose update core.
//
// A queue-fed driver sends odometry/pose transactions and a monitor checks
// every response against a bit-accurate predictor of the vectoring and
// rotation CORDIC update. The run walks through omni, differential and
// unsupported modes with several thresholds and idle/stall patterns.
// ----------------------------------------------------------------------------
module odometry_pose_update_core_test import ocpu_pkg::*; ();

   localparam logic [1:0] MODE_UNSUP = 2'd2;
   localparam logic [1:0] MODE_UNSUP_HI = 2'd3;
   localparam int STAGES = 16;
   localparam int LATENCY = 2 * STAGES + 8;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      bit signed [31:0] prev_x, prev_y, new_x, new_y, pose_x, pose_y;
      bit [15:0]        prev_h, new_h, pose_h;
   } odom_req_type;

   typedef struct {
      bit [31:0] x, y;
      bit [15:0] h;
      bit        ok;
   } pose_rsp_type;

   logic        clock, reset;
   logic        req_valid, req_stall;
   logic [31:0] req_prev_odom_x, req_prev_odom_y, req_new_odom_x, req_new_odom_y;
   logic [31:0] req_pose_x, req_pose_y;
   logic [15:0] req_prev_odom_heading, req_new_odom_heading, req_pose_heading;
   logic        rsp_valid, rsp_stall;
   logic [31:0] rsp_out_x, rsp_out_y;
   logic [15:0] rsp_out_heading;
   logic        rsp_model_ok;
   logic        csr_valid, csr_ready, csr_index;
   logic [15:0] csr_wdata;

   odometry_pose_update_core #(.CORDIC_STAGES(STAGES)) dut (.*);

   odom_req_type pending_reqs[$];
   pose_rsp_type expected_poses[$];
   bit [1:0]     cur_mode;
   bit [15:0]    cur_min_trans;
   bit [63:0]    gain_recip;
   int           send_idle_pct, rsp_stall_pct;
   int           mismatches;
   int           cycles;
   bit           req_taken;

   function automatic void queue_req(input odom_req_type r);
      pending_reqs.insert(pending_reqs.size(), r);
   endfunction

   function automatic void cordic_rotate(input longint x0, input bit [31:0] a0,
                                         output longint ox, output longint oy);
      longint x, y, z, xs, ys;
      bit [31:0] a;
      x = x0;
      y = 0;
      a = a0;
      if (a[31:30] == 2'd1 || a[31:30] == 2'd2) begin
         a = a + 32'h8000_0000;
         x = -x;
      end
      z = a[31] ? longint'(a) - 64'sh1_0000_0000 : longint'(a);
      for (int i = 0; i < STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - longint'(ATAN_TAB[i]);
         end else begin
            x = x + ys; y = y - xs; z = z + longint'(ATAN_TAB[i]);
         end
      end
      ox = x;
      oy = y;
   endfunction

   function automatic longint gain_scale(input longint v);
      bit        neg;
      bit [63:0] m, r;
      neg = v < 0;
      m = neg ? -v : v;
      r = (m * gain_recip + (64'd1 << 29)) >> 30;
      return neg ? -longint'(r) : longint'(r);
   endfunction

   function automatic bit [31:0] sat32(input longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic pose_rsp_type predict_pose(input odom_req_type r);
      pose_rsp_type p;
      longint    dx, dy, x, y, xs, ys, trans, cx, cy;
      bit [31:0] z, t;
      bit [15:0] bearing, rot1, travel;
      if (cur_mode != MODE_OMNI && cur_mode != MODE_DIFF) begin
         p.x = r.pose_x; p.y = r.pose_y; p.h = r.pose_h; p.ok = 0;
         return p;
      end
      dx = longint'(r.new_x) - longint'(r.prev_x);
      dy = longint'(r.new_y) - longint'(r.prev_y);
      trans = 0;
      bearing = 0;
      if (dx != 0 || dy != 0) begin
         x = dx; y = dy; z = 0;
         if (x < 0) begin
            x = -x; y = -y; z = 32'h8000_0000;
         end
         for (int i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x = x + ys; y = y - xs; z = z + ATAN_TAB[i];
            end else begin
               x = x - ys; y = y + xs; z = z - ATAN_TAB[i];
            end
         end
         trans = gain_scale(x);
         t = z + 32'h8000;
         bearing = t[31:16];
      end
      if (cur_mode == MODE_OMNI)
         travel = r.pose_h + bearing - r.prev_h;
      else begin
         rot1 = (trans < longint'(cur_min_trans)) ? 16'd0 : bearing - r.prev_h;
         travel = r.pose_h + rot1;
      end
      cordic_rotate(trans, {travel, 16'h0}, cx, cy);
      p.x = sat32(longint'(r.pose_x) + gain_scale(cx));
      p.y = sat32(longint'(r.pose_y) + gain_scale(cy));
      p.h = r.pose_h + (r.new_h - r.prev_h);
      p.ok = 1;
      return p;
   endfunction

   function automatic bit signed [31:0] rand_pos();
      case ($urandom_range(5))
         0: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         1, 2: return $urandom;
         default: return $signed($urandom_range(2000000)) - 1000000;
      endcase
   endfunction

   function automatic bit signed [31:0] near(input bit signed [31:0] base);
      int k;
      longint v;
      k = $urandom_range(24);
      v = longint'(base) + longint'($signed($urandom_range((1 << k) * 2))) - (1 << k);
      if ($urandom_range(9) == 0) v = base;
      return sat32(v);
   endfunction

   function automatic odom_req_type random_req();
      odom_req_type r;
      r.prev_x = rand_pos();
      r.prev_y = rand_pos();
      if ($urandom_range(3) == 0) begin
         r.new_x = rand_pos();
         r.new_y = rand_pos();
      end else begin
         r.new_x = near(r.prev_x);
         r.new_y = near(r.prev_y);
      end
      r.pose_x = rand_pos();
      r.pose_y = rand_pos();
      r.prev_h = $urandom;
      r.new_h = $urandom_range(1) ? 16'($urandom) : r.prev_h + 16'($urandom_range(2000));
      r.pose_h = $urandom;
      return r;
   endfunction

   function automatic odom_req_type make_req(input bit signed [31:0] px0, py0, nx, ny,
                                             input bit [15:0] ph0, nh,
                                             input bit signed [31:0] qx, qy,
                                             input bit [15:0] qh);
      odom_req_type r;
      r.prev_x = px0; r.prev_y = py0; r.new_x = nx; r.new_y = ny;
      r.prev_h = ph0; r.new_h = nh; r.pose_x = qx; r.pose_y = qy; r.pose_h = qh;
      return r;
   endfunction

   task automatic csr_write(input logic idx, input logic [15:0] data);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_MODEL_MODE) cur_mode = data[1:0];
      else cur_min_trans = data;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || req_valid || expected_poses.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // driver
   always @(negedge clock) begin : driver
      odom_req_type r;
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || req_taken) begin
         req_taken = 0;
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            r = pending_reqs.pop_front();
            req_prev_odom_x <= r.prev_x;
            req_prev_odom_y <= r.prev_y;
            req_prev_odom_heading <= r.prev_h;
            req_new_odom_x <= r.new_x;
            req_new_odom_y <= r.new_y;
            req_new_odom_heading <= r.new_h;
            req_pose_x <= r.pose_x;
            req_pose_y <= r.pose_y;
            req_pose_heading <= r.pose_h;
            req_valid <= 1;
         end else begin
            req_valid <= 0;
         end
      end
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // accept side: predict on every accepted transaction
   always @(posedge clock) begin : acceptor
      odom_req_type r;
      if (!reset && req_valid && !req_stall) begin
         r = make_req(req_prev_odom_x, req_prev_odom_y, req_new_odom_x, req_new_odom_y,
                      req_prev_odom_heading, req_new_odom_heading,
                      req_pose_x, req_pose_y, req_pose_heading);
         expected_poses.insert(expected_poses.size(), predict_pose(r));
         req_taken = 1;
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      pose_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_poses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transaction: x=%h y=%h h=%h ok=%b",
                        rsp_out_x, rsp_out_y, rsp_out_heading, rsp_model_ok);
         end else begin
            e = expected_poses.pop_front();
            if (rsp_out_x !== e.x || rsp_out_y !== e.y || rsp_out_heading !== e.h ||
                rsp_model_ok !== e.ok) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp x=%h y=%h h=%h ok=%b, got x=%h y=%h h=%h ok=%b",
                           e.x, e.y, e.h, e.ok, rsp_out_x, rsp_out_y,
                           rsp_out_heading, rsp_model_ok);
            end
         end
      end
   end

   initial begin : stimulus
      longint      kx, ky;
      logic [1:0]  modes[8];
      logic [15:0] thresholds[8];
      cycles = 0;
      mismatches = 0;
      req_taken = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      cur_mode = MODE_DIFF;
      cur_min_trans = 16'd655;
      reset = 1;
      req_valid = 0;
      rsp_stall = 0;
      csr_valid = 0;
      csr_index = CSR_MODEL_MODE;
      csr_wdata = 0;
      {req_prev_odom_x, req_prev_odom_y, req_new_odom_x, req_new_odom_y} = '0;
      {req_pose_x, req_pose_y} = '0;
      {req_prev_odom_heading, req_new_odom_heading, req_pose_heading} = '0;
      cordic_rotate(longint'(1) << 30, 32'd0, kx, ky);
      if (kx <= 0) kx = longint'(1) << 30;
      gain_recip = ((64'd1 << 60) + (kx >> 1)) / kx;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed, default config (diff, 655)
      queue_req(make_req(100, 200, 100, 200, 16'h1234, 16'h1234,
                         5, 6, 16'h4000));
      queue_req(make_req(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                         32'sh7FFF_FFFF, 16'h8000, 16'h7FFF,
                         32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'h0000));
      queue_req(make_req(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                         32'sh8000_0000, 16'h7FFF, 16'h8000,
                         32'sh8000_0000, 32'sh8000_0000, 16'hFFFF));
      queue_req(make_req(0, 0, -65536, 0, 0, 16'h8000, 0, 0, 16'h2000));
      queue_req(make_req(0, 0, 0, 65536, 16'h4000, 0, 0, 0, 0));
      queue_req(make_req(0, 0, 0, -65536, 0, 16'hC000, 0, 0, 16'h8000));
      queue_req(make_req(0, 0, 300, 300, 16'h1000, 16'h1100, 0, 0, 0));
      queue_req(make_req(0, 0, 654, 0, 16'h1000, 16'h1000, 7, 7, 16'h0100));
      queue_req(make_req(0, 0, 655, 0, 16'h1000, 16'h1000, 7, 7, 16'h0100));
      queue_req(make_req(0, 0, 32'sh4000_0000, 0, 0, 0,
                         32'sh7000_0000, 0, 0));
      queue_req(make_req(0, 0, -32'sh4000_0000, 0, 0, 0,
                         -32'sh7000_0000, 0, 0));
      queue_req(make_req(0, 0, 0, 32'sh4000_0000, 0, 0,
                         0, 32'sh7000_0000, 16'h4000));
      queue_req(make_req(-1, -1, 1, 1, 16'hFFFF, 16'h0001,
                         -1, -1, 16'h7FFF));
      queue_req(make_req(5, 5, 5, 5, 16'h8000, 16'h7FFF, 32'sh7FFF_FFFF,
                         32'sh8000_0000, 16'h8000));
      drain();

      modes = '{MODE_OMNI, MODE_DIFF, MODE_DIFF, MODE_UNSUP, MODE_OMNI,
                MODE_DIFF, MODE_UNSUP_HI, MODE_DIFF};
      thresholds = '{16'd0, 16'd655, 16'hFFFF, 16'd1234, 16'hFFFF, 16'd0,
                     16'hAAAA, 16'd30000};
      for (int phase = 0; phase < 8; phase++) begin
         csr_write(CSR_MODEL_MODE, {14'($urandom), modes[phase]});
         csr_write(CSR_MIN_TRANSLATION, thresholds[phase]);
         case (phase % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 86; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 86; end
            default: begin send_idle_pct = 27; rsp_stall_pct = 27; end
         endcase
         if (phase == 0) begin
            // omni handles the directed extremes too
            queue_req(make_req(0, 0, -65536, 0, 16'h4000, 0, 0, 0, 16'h2000));
            queue_req(make_req(32'sh8000_0000, 0, 32'sh7FFF_FFFF, 0, 0, 0,
                               32'sh7FFF_FFFF, 0, 0));
         end
         for (int n = 0; n < 210; n++)
            queue_req(random_req());
         drain();
      end

      if (mismatches == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
